// ===== rtl/can_frame_change_filter_assert.svh =====
// Assertion macros for the CAN frame change filter, clocked on aclk, off during reset.
`ifndef CAN_FRAME_CHANGE_FILTER_ASSERT_SVH
`define CAN_FRAME_CHANGE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define CFCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CFCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfcf_pkg.sv =====
// Shared types, codes and helpers of the CAN frame change filter.
`default_nettype none

package cfcf_pkg;

    localparam int ID_W       = 29;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int REASON_W   = 3;
    localparam int SLOT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRINT_IVAL   = 2'd2;

    localparam logic [INTERVAL_W-1:0] REPRINT_IVAL_RESET = 16'd500;

    // result reason codes
    localparam logic [REASON_W-1:0] REASON_UNCHANGED  = 3'd0;
    localparam logic [REASON_W-1:0] REASON_NEW        = 3'd1;
    localparam logic [REASON_W-1:0] REASON_CHANGED    = 3'd2;
    localparam logic [REASON_W-1:0] REASON_DUE        = 3'd3;
    localparam logic [REASON_W-1:0] REASON_FULL       = 3'd4;
    localparam logic [REASON_W-1:0] REASON_FILTER_OFF = 3'd5;
    localparam logic [REASON_W-1:0] REASON_OUTPUT_OFF = 3'd6;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] payload;
        logic [TIME_W-1:0] report_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Byte-enable mask for a length; lengths above eight cover all bytes.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        for (int b = 0; b < DATA_W / 8; b++) begin
            m[8*b +: 8] = {8{len > LEN_W'(b)}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfcf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port with enable.
`default_nettype none

module cfcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/can_frame_change_filter.sv =====
// CAN frame change filter: top level with the entry scan sequencer and result register.
// With output and filter enabled, each accepted frame is checked against a table of
// TABLE_ENTRIES tracked identifiers that sits in one RAM with a registered read port; a
// sequencer reads one entry per cycle and compares it, while per-entry used flags (cleared
// at reset) are tracked in flip-flops and the lowest free entry is noted during the same
// pass. A frame whose identifier misses scans every entry and then passes through FINISH;
// a hit stops the scan and passes through EVAL and FINISH. With output or filter switched
// off the frame goes straight to FINISH. The entry scan over the single RAM read port sets
// how long a frame takes. s_ready returns in the cycle after the result loads and is high
// only between frames. A finished result is loaded only once the output register is free;
// while a previous result still waits there the sequencer holds in FINISH. After loading,
// the next frame is not blocked. Reports of new, changed or due frames update the matched
// or claimed entry in the same cycle the result is loaded.
`default_nettype none

module can_frame_change_filter
    import cfcf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // frame input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ID_W-1:0]       s_frame_id,
    input  wire logic [LEN_W-1:0]      s_length,
    input  wire logic [DATA_W-1:0]     s_data_bytes,
    input  wire logic [TIME_W-1:0]     s_now_ms,
    // result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_report,
    output logic [REASON_W-1:0]        m_reason,
    output logic [SLOT_W-1:0]          m_slot
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    logic                  output_enable_reg, output_enable_next;
    logic                  filter_enable_reg, filter_enable_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [ID_W-1:0]   id_reg, id_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [DATA_W-1:0] payload_reg, payload_next;
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic                res_report_reg, res_report_next;
    logic [REASON_W-1:0] res_reason_reg, res_reason_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                res_wr_reg, res_wr_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_report_reg, m_report_next;
    logic [REASON_W-1:0] m_reason_reg, m_reason_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;

    logic [TABLE_ENTRIES-1:0] used_reg, used_next;

    logic             ram_we;
    logic             ram_re;
    entry_t           ram_wdata;
    entry_t           rd_entry;
    logic             hit;
    logic             changed;
    logic             due;
    logic [TIME_W-1:0] elapsed;

    cfcf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (res_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    assign ram_wdata = '{frame_id: id_reg, length: len_reg, payload: payload_reg,
                         report_time: now_reg};

    assign hit     = cmp_vld_reg && used_reg[cmp_idx_reg] && (rd_entry.frame_id == id_reg);
    assign changed = (rd_entry.length != len_reg) ||
                     ((rd_entry.payload & mask_reg) != payload_reg);
    assign elapsed = now_reg - rd_entry.report_time;   // wraps modulo 2^32
    assign due     = elapsed >= {{(TIME_W - INTERVAL_W){1'b0}}, interval_reg};

    // Hold the read data once a hit is seen so EVAL sees the matched entry.
    assign ram_re  = (state_reg == ST_SCAN) && !issue_done_reg && !hit;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        output_enable_next = output_enable_reg;
        filter_enable_next = filter_enable_reg;
        interval_next      = interval_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OUTPUT_ENABLE: output_enable_next = cfg_wr_data[0];
                CFG_FILTER_ENABLE: filter_enable_next = cfg_wr_data[0];
                CFG_REPRINT_IVAL:  interval_next      = cfg_wr_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        payload_next    = payload_reg;
        mask_next       = mask_reg;
        now_next        = now_reg;
        res_report_next = res_report_reg;
        res_reason_next = res_reason_reg;
        res_idx_next    = res_idx_reg;
        res_wr_next     = res_wr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_report_next   = m_report_reg;
        m_reason_next   = m_reason_reg;
        m_slot_next     = m_slot_reg;
        used_next       = used_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    id_next         = s_frame_id;
                    len_next        = s_length;
                    mask_next       = byte_mask(s_length);
                    payload_next    = s_data_bytes & byte_mask(s_length);
                    now_next        = s_now_ms;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    res_idx_next    = '0;
                    res_wr_next     = 1'b0;
                    if (!output_enable_reg) begin
                        res_report_next = 1'b0;
                        res_reason_next = REASON_OUTPUT_OFF;
                        state_next      = ST_FINISH;
                    end else if (!filter_enable_reg) begin
                        res_report_next = 1'b1;
                        res_reason_next = REASON_FILTER_OFF;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue side: one read per cycle, note the lowest free entry
                if (!issue_done_reg) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (!used_reg[scan_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                // compare side: data of the entry read last cycle
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    res_idx_next = cmp_idx_reg;
                    state_next   = ST_EVAL;
                end else if (cmp_vld_reg && cmp_idx_reg == LAST_IDX) begin
                    cmp_vld_next    = 1'b0;
                    res_report_next = 1'b1;
                    if (free_found_reg) begin
                        res_reason_next = REASON_NEW;
                        res_idx_next    = free_idx_reg;
                        res_wr_next     = 1'b1;
                    end else begin
                        res_reason_next = REASON_FULL;
                        res_idx_next    = '0;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_EVAL: begin
                res_report_next = changed || due;
                res_wr_next     = changed || due;
                priority if (changed) begin
                    res_reason_next = REASON_CHANGED;
                end else if (due) begin
                    res_reason_next = REASON_DUE;
                end else begin
                    res_reason_next = REASON_UNCHANGED;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_report_next = res_report_reg;
                    m_reason_next = res_reason_reg;
                    m_slot_next   = SLOT_W'(res_idx_reg);
                    if (res_wr_reg) begin
                        ram_we                 = 1'b1;
                        used_next[res_idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            output_enable_reg <= 1'b1;
            filter_enable_reg <= 1'b1;
            interval_reg      <= REPRINT_IVAL_RESET;
            issue_done_reg    <= 1'b0;
            cmp_vld_reg       <= 1'b0;
            free_found_reg    <= 1'b0;
            res_wr_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
            used_reg          <= '0;
        end else begin
            state_reg         <= state_next;
            output_enable_reg <= output_enable_next;
            filter_enable_reg <= filter_enable_next;
            interval_reg      <= interval_next;
            issue_done_reg    <= issue_done_next;
            cmp_vld_reg       <= cmp_vld_next;
            free_found_reg    <= free_found_next;
            res_wr_reg        <= res_wr_next;
            m_valid_reg       <= m_valid_next;
            used_reg          <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_idx_reg   <= free_idx_next;
        id_reg         <= id_next;
        len_reg        <= len_next;
        payload_reg    <= payload_next;
        mask_reg       <= mask_next;
        now_reg        <= now_next;
        res_report_reg <= res_report_next;
        res_reason_reg <= res_reason_next;
        res_idx_reg    <= res_idx_next;
        m_report_reg   <= m_report_next;
        m_reason_reg   <= m_reason_next;
        m_slot_reg     <= m_slot_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_report = m_report_reg;
    assign m_reason = m_reason_reg;
    assign m_slot   = m_slot_reg;

`include "can_frame_change_filter_assert.svh"

    `CFCF_ASSERT_NOW(a_report_matches_reason, m_valid,
        m_report == ((m_reason != REASON_UNCHANGED) && (m_reason != REASON_OUTPUT_OFF)),
        "report flag disagrees with reason")
    `CFCF_ASSERT_NOW(a_no_slot_untracked,
        m_valid && (m_reason == REASON_FULL || m_reason == REASON_FILTER_OFF ||
                    m_reason == REASON_OUTPUT_OFF),
        m_slot == '0, "untracked result carries a slot")
    `CFCF_ASSERT_NEXT(a_write_marks_used, ram_we, used_reg[$past(res_idx_reg)],
        "table write did not mark entry used")
    `CFCF_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "ready again right after a transaction")

endmodule

`default_nettype wire
